@@ design/ray_triangle_intersect_macros.svh @@
// Assertion macros for the ray/triangle intersection checker.
// Needs a clock named clk and a reset named rst in the using module.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray_triangle_intersect assertion failed");

// Next-cycle implication, disabled during reset.
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray_triangle_intersect assertion failed");

`endif

@@ design/rti_pkg.sv @@
// Shared codes and fixed field widths for the ray/triangle intersection block.
// No dependencies.
package rti_pkg;

  localparam int COORD_BITS = 32;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_RAY    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    AXIS_X  = 2'd0,
    AXIS_Y  = 2'd1,
    AXIS_Z  = 2'd2,
    AXIS_ZZ = 2'd3
  } axis_t;

  localparam logic [1:0]  AXIS_MASK        = 2'h3;
  localparam logic [1:0]  AXIS_RESET       = 2'd2;
  localparam logic [16:0] THRESHOLD_RESET  = 17'd66;

endpackage

@@ design/ray_triangle_intersect.sv @@
// Ray/triangle intersection engine: one ray beat per cycle while the result
// side is not stalled. The pipeline is 44 register stages; the restoring
// divider for t takes 33 of them, one quotient bit per stage.
// Synchronous active-high reset clears the stage valid bits, sets the
// projection axis to z and the parallel threshold to 66. Vertex and normal
// registers are undefined until loaded.
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          kind,
  input  logic [1:0]          vertex_slot,
  input  logic signed [31:0]  first_x,
  input  logic signed [31:0]  first_y,
  input  logic signed [31:0]  first_z,
  input  logic signed [31:0]  second_x,
  input  logic signed [31:0]  second_y,
  input  logic signed [31:0]  second_z,
  input  logic [1:0]          axis_choice,
  input  logic signed [31:0]  near_limit,
  input  logic signed [31:0]  far_limit,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                hit,
  output logic                entering,
  output logic signed [31:0]  distance,
  input  logic                cfg_write_enable,
  input  logic [16:0]         cfg_write_data
);

  // Widths. Products of two coordinates are floored by FRAC_BITS, and the
  // three-term sums get two guard bits so they never overflow.
  localparam int W   = rti_pkg::COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PRW = 2 * W - F;        // floored coord * coord
  localparam int PNW = 2 * W + 1 - F;    // floored normal * (origin - v0)
  localparam int DW  = PRW + 2;          // N.D
  localparam int NW  = PNW + 2;          // N.(O - V0)
  localparam int XW  = NW + F;           // dividend |num| << F
  localparam int QW  = W + 1;            // quotient bits kept
  localparam int PW  = 2 * W - F + 1;    // projected hit point
  localparam int EW  = PW + 1;           // edge test differences
  localparam int MW  = W + 1;            // bounded edge magnitudes
  localparam int WL  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  // Stage map.
  localparam int S_IN  = 0;
  localparam int S_MUL = 1;
  localparam int S_SUM = 2;
  localparam int S_MAG = 3;
  localparam int S_PRE = 4;
  localparam int S_DIV = 5;
  localparam int S_SAT = S_DIV + QW;
  localparam int S_TM  = S_SAT + 1;
  localparam int S_ADD = S_TM + 1;
  localparam int S_E1  = S_ADD + 1;
  localparam int S_E2  = S_E1 + 1;
  localparam int S_OUT = S_E2 + 1;
  localparam int NS    = S_OUT + 1;

  localparam logic [QW-1:0] CAP_NEG = QW'(1) << (WL - 1);
  localparam logic [QW-1:0] CAP_POS = CAP_NEG - QW'(1);

  typedef struct packed {
    logic signed [W-1:0]   ox, oy, oz, dx, dy, dz, nrx, nry, nrz;
    logic signed [W-1:0]   near_l, far_l, oa, ob, da, db, t;
    logic signed [W:0]     p0, p1, p2;
    logic [2:0][W-1:0]     va, vb;
    logic signed [PRW-1:0] pd0, pd1, pd2, mta, mtb;
    logic signed [PNW-1:0] pn0, pn1, pn2;
    logic signed [DW-1:0]  dsum;
    logic signed [NW-1:0]  nsum;
    logic [DW-1:0]         ud;
    logic [NW-1:0]         un;
    logic                  par, ent, neg, sat, miss, hit;
    logic [DW:0]           rem;
    logic [QW-1:0]         xl, q;
    logic signed [PW-1:0]  hx, hy;
    logic [2:0]            skip, tru, flat, bneg;
    logic [2:0][MW-1:0]    ua, ub, uc, ue;
    logic [2:0][2*MW-1:0]  pa, pb;
  } ray_t;

  // Triangle storage and the threshold register.
  logic signed [W-1:0] vx [3];
  logic signed [W-1:0] vy [3];
  logic signed [W-1:0] vz [3];
  logic signed [W-1:0] nrm_x, nrm_y, nrm_z;
  logic [1:0]          axis;
  logic [16:0]         threshold;

  ray_t st [NS];
  ray_t st_next [NS];
  logic vld [NS];

  logic adv;
  logic accept;

  // The whole pipeline moves together; it only halts when a finished
  // result is waiting and the consumer stalls.
  assign adv      = !(vld[NS-1] && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis      <= rti_pkg::AXIS_RESET;
      threshold <= rti_pkg::THRESHOLD_RESET;
    end else begin
      if (cfg_write_enable) begin
        threshold <= cfg_write_data;
      end
      if (accept && kind == rti_pkg::KIND_NORMAL) begin
        axis <= axis_choice & rti_pkg::AXIS_MASK;
      end
    end
  end

  // Load beats update the triangle on acceptance. A ray accepted later
  // reads the new values; rays already in flight carry their own copy.
  always_ff @(posedge clk) begin
    if (accept && kind == rti_pkg::KIND_VERTEX && vertex_slot != 2'd3) begin
      vx[vertex_slot] <= first_x;
      vy[vertex_slot] <= first_y;
      vz[vertex_slot] <= first_z;
    end
    if (accept && kind == rti_pkg::KIND_NORMAL) begin
      nrm_x <= first_x;
      nrm_y <= first_y;
      nrm_z <= first_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid && kind == rti_pkg::KIND_RAY;
      for (int i = 1; i < NS; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) begin
        st[i] <= st_next[i];
      end
    end
  end

  always_comb begin
    ray_t s;
    logic [XW-1:0] xfull;
    logic [XW-1:0] xsh;
    logic [DW:0]   rs;
    logic [QW-1:0] qq;
    logic signed [EW-1:0] ex, ey, x0, y0, x1, y1, av, cv;
    logic signed [W:0] bv, ev;
    logic [2:0] tog;

    // Entry: capture the ray and a snapshot of the triangle, projected
    // onto the plane that drops the configured projection axis.
    s        = '0;
    s.ox     = first_x;
    s.oy     = first_y;
    s.oz     = first_z;
    s.dx     = second_x;
    s.dy     = second_y;
    s.dz     = second_z;
    s.near_l = near_limit;
    s.far_l  = far_limit;
    s.nrx    = nrm_x;
    s.nry    = nrm_y;
    s.nrz    = nrm_z;
    s.p0     = (W+1)'(first_x) - (W+1)'(vx[0]);
    s.p1     = (W+1)'(first_y) - (W+1)'(vy[0]);
    s.p2     = (W+1)'(first_z) - (W+1)'(vz[0]);
    unique case (axis)
      rti_pkg::AXIS_X: begin
        s.oa = first_y;
        s.ob = first_z;
        s.da = second_y;
        s.db = second_z;
        for (int i = 0; i < 3; i++) begin
          s.va[i] = vy[i];
          s.vb[i] = vz[i];
        end
      end
      rti_pkg::AXIS_Y: begin
        s.oa = first_x;
        s.ob = first_z;
        s.da = second_x;
        s.db = second_z;
        for (int i = 0; i < 3; i++) begin
          s.va[i] = vx[i];
          s.vb[i] = vz[i];
        end
      end
      default: begin
        s.oa = first_x;
        s.ob = first_y;
        s.da = second_x;
        s.db = second_y;
        for (int i = 0; i < 3; i++) begin
          s.va[i] = vx[i];
          s.vb[i] = vy[i];
        end
      end
    endcase
    st_next[S_IN] = s;

    // Six floored products.
    s     = st[S_IN];
    s.pd0 = PRW'(((2*W)'(s.nrx) * (2*W)'(s.dx)) >>> F);
    s.pd1 = PRW'(((2*W)'(s.nry) * (2*W)'(s.dy)) >>> F);
    s.pd2 = PRW'(((2*W)'(s.nrz) * (2*W)'(s.dz)) >>> F);
    s.pn0 = PNW'(((2*W+1)'(s.nrx) * (2*W+1)'(s.p0)) >>> F);
    s.pn1 = PNW'(((2*W+1)'(s.nry) * (2*W+1)'(s.p1)) >>> F);
    s.pn2 = PNW'(((2*W+1)'(s.nrz) * (2*W+1)'(s.p2)) >>> F);
    st_next[S_MUL] = s;

    // Dot products.
    s      = st[S_MUL];
    s.dsum = DW'(s.pd0) + DW'(s.pd1) + DW'(s.pd2);
    s.nsum = NW'(s.pn0) + NW'(s.pn1) + NW'(s.pn2);
    st_next[S_SUM] = s;

    // Magnitudes, sign of t and the parallel test.
    s     = st[S_SUM];
    s.ud  = s.dsum[DW-1] ? DW'(-s.dsum) : DW'(s.dsum);
    s.un  = s.nsum[NW-1] ? NW'(-s.nsum) : NW'(s.nsum);
    s.par = (s.dsum == '0) || (s.ud < DW'(threshold));
    s.ent = s.dsum[DW-1];
    s.neg = (s.nsum != '0) && (s.nsum[NW-1] == s.dsum[DW-1]);
    st_next[S_MAG] = s;

    // Divider setup. A quotient that would need more than QW bits is
    // flagged here and saturates regardless of the bits that follow.
    s     = st[S_MAG];
    s.sat = XW'(s.un) >= (XW'(s.ud) << (QW - F));
    xfull = XW'(s.un) << F;
    xsh   = xfull >> QW;
    s.rem = xsh[DW:0];
    s.xl  = xfull[QW-1:0];
    s.q   = '0;
    st_next[S_PRE] = s;

    // One restoring division step per stage, most significant bit first.
    for (int k = 0; k < QW; k++) begin
      s  = st[S_DIV+k-1];
      rs = {s.rem[DW-1:0], s.xl[QW-1-k]};
      if (rs >= {1'b0, s.ud}) begin
        s.rem = rs - {1'b0, s.ud};
        s.q   = {s.q[QW-2:0], 1'b1};
      end else begin
        s.rem = rs;
        s.q   = {s.q[QW-2:0], 1'b0};
      end
      st_next[S_DIV+k] = s;
    end

    // Saturate and sign t.
    s = st[S_SAT-1];
    if (s.neg) begin
      qq  = (s.sat || s.q > CAP_NEG) ? CAP_NEG : s.q;
      s.t = W'(-qq);
    end else begin
      qq  = (s.sat || s.q > CAP_POS) ? CAP_POS : s.q;
      s.t = W'(qq);
    end
    st_next[S_SAT] = s;

    // Range check and direction times t on the two kept axes.
    s      = st[S_SAT];
    s.miss = s.par || (s.t < s.near_l) || (s.t > s.far_l);
    s.mta  = PRW'(((2*W)'(s.da) * (2*W)'(s.t)) >>> F);
    s.mtb  = PRW'(((2*W)'(s.db) * (2*W)'(s.t)) >>> F);
    st_next[S_TM] = s;

    s    = st[S_TM];
    s.hx = PW'(s.oa) + PW'(s.mta);
    s.hy = PW'(s.ob) + PW'(s.mtb);
    st_next[S_ADD] = s;

    // Edge classification. Where the cross test is reached, the point lies
    // within the edge's box, so the magnitudes fit in W+1 bits.
    s  = st[S_ADD];
    ex = EW'(s.hx);
    ey = EW'(s.hy);
    for (int i = 0; i < 3; i++) begin
      x0 = EW'($signed(s.va[i]));
      y0 = EW'($signed(s.vb[i]));
      x1 = EW'($signed(s.va[(i+1)%3]));
      y1 = EW'($signed(s.vb[(i+1)%3]));
      s.skip[i] = (y0 < ey && y1 < ey) || (y0 > ey && y1 > ey) ||
                  (x0 < ex && x1 < ex);
      s.tru[i]  = x0 > ex && x1 > ex;
      s.flat[i] = y0 == y1;
      s.bneg[i] = x1 < x0;
      av = ex - x0;
      cv = y0 - ey;
      bv = (W+1)'($signed(s.va[(i+1)%3])) - (W+1)'($signed(s.va[i]));
      ev = (W+1)'($signed(s.vb[i])) - (W+1)'($signed(s.vb[(i+1)%3]));
      s.ua[i] = av[EW-1] ? MW'(-av) : MW'(av);
      s.uc[i] = cv[EW-1] ? MW'(-cv) : MW'(cv);
      s.ub[i] = bv[W] ? MW'(-bv) : MW'(bv);
      s.ue[i] = ev[W] ? MW'(-ev) : MW'(ev);
    end
    st_next[S_E1] = s;

    s = st[S_E1];
    for (int i = 0; i < 3; i++) begin
      s.pa[i] = (2*MW)'(s.ua[i]) * (2*MW)'(s.ue[i]);
      s.pb[i] = (2*MW)'(s.ub[i]) * (2*MW)'(s.uc[i]);
    end
    st_next[S_E2] = s;

    // Crossing parity and the result fields.
    s = st[S_E2];
    for (int i = 0; i < 3; i++) begin
      priority if (s.skip[i]) begin
        tog[i] = 1'b0;
      end else if (s.tru[i]) begin
        tog[i] = 1'b1;
      end else if (s.flat[i]) begin
        tog[i] = 1'b0;
      end else if (s.bneg[i]) begin
        tog[i] = s.pa[i] > s.pb[i];
      end else begin
        tog[i] = s.pa[i] < s.pb[i];
      end
    end
    s.hit = !s.miss && (^tog);
    s.ent = !s.par && s.ent;
    if (!s.hit) begin
      s.t = '0;
    end
    st_next[S_OUT] = s;
  end

  assign out_valid = vld[NS-1];
  assign hit       = st[NS-1].hit;
  assign entering  = st[NS-1].ent;
  assign distance  = st[NS-1].t;

endmodule

@@ design/ray_triangle_intersect_checker.sv @@
// Port-level checker for the ray/triangle intersection engine, bound to it.
// Uses the assertion macros header.
`include "ray_triangle_intersect_macros.svh"

module ray_triangle_intersect_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               hit,
  input logic               entering,
  input logic signed [31:0] distance
);

  // A stalled result beat holds.
  `RTI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(entering) && $stable(distance))

  // A miss reports zero distance.
  `RTI_ASSERT_IMP(a_miss_zero, out_valid && !hit, distance == 32'sd0)

  // The input side only stalls behind a blocked result.
  `RTI_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

  // With the result taken, the input side is open.
  `RTI_ASSERT_IMP(a_no_idle_stall, !(out_valid && out_stall), !in_stall)

endmodule

bind ray_triangle_intersect ray_triangle_intersect_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .entering  (entering),
  .distance  (distance)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for ray_triangle_intersect: a scoreboard class with
// its own Q16.16 intersection predictor, plus driver tasks for both channels.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One input beat, kept with typed fields at the widths of the block.
  typedef struct {
    rti_pkg::kind_t     kind;
    logic [1:0]         slot;
    logic signed [31:0] org[3];
    logic signed [31:0] dir[3];
    logic [1:0]         axis;
    logic signed [31:0] near_t;
    logic signed [31:0] far_t;
  } beat_t;

  typedef struct {
    logic               hit;
    logic               entering;
    logic signed [31:0] distance;
  } hit_result_t;

  typedef logic signed [95:0] wide_t;

  // Holds the triangle and threshold as the block should see them, works out
  // the result of every accepted ray and compares arriving results in order.
  class hit_scoreboard;
    longint          tri_vtx[9];
    longint          tri_norm[3];
    logic [1:0]      proj_axis;
    logic [16:0]     threshold;
    hit_result_t     pending_hits[$];
    int              errors;
    int              rays_seen;
    int              hits_seen;

    function new();
      foreach (tri_vtx[i]) tri_vtx[i] = 0;
      foreach (tri_norm[i]) tri_norm[i] = 0;
      proj_axis = rti_pkg::AXIS_RESET;
      threshold = rti_pkg::THRESHOLD_RESET;
      errors = 0;
      rays_seen = 0;
      hits_seen = 0;
    endfunction

    function void set_threshold(logic [16:0] value);
      threshold = value;
    endfunction

    static function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(0) - v : v;
    endfunction

    // Floor of a*b / 2^16, taken on a product that cannot overflow.
    static function longint scaled_product(longint a, longint b);
      wide_t prod;
      prod = wide_t'(a) * wide_t'(b);
      return longint'(prod >>> 16);
    endfunction

    // Crossing-parity contribution of one projected edge. The cross products
    // are kept to 64 bits, while the RTL keeps them to 2*(W+1) bits.
    static function bit edge_crosses(longint x0, longint y0, longint x1, longint y1,
                                     longint x, longint y);
      longint unsigned ua, ub, uc, ue;
      if ((y0 < y && y1 < y) || (y0 > y && y1 > y) || (x0 < x && x1 < x))
        return 0;
      if (x0 > x && x1 > x)
        return 1;
      // A horizontal edge at the point's height never counts.
      if (y0 == y1)
        return 0;
      ua = magnitude(x - x0);
      ub = magnitude(x1 - x0);
      uc = magnitude(y0 - y);
      ue = magnitude(y0 - y1);
      if (x1 - x0 >= 0)
        return (ua * ue) < (ub * uc);
      return (ua * ue) > (ub * uc);
    endfunction

    function void note_input(beat_t b);
      longint            o[3], dv[3], dot_d, dot_n, t, px, py;
      longint unsigned   un, ud, q, r;
      bit                neg, inside_tri;
      int                ia, ib, j;
      hit_result_t       res;
      for (int i = 0; i < 3; i++) begin
        o[i] = b.org[i];
        dv[i] = b.dir[i];
      end
      if (b.kind == rti_pkg::KIND_VERTEX) begin
        if (b.slot < 3)
          for (int i = 0; i < 3; i++) tri_vtx[b.slot * 3 + i] = o[i];
        return;
      end
      if (b.kind == rti_pkg::KIND_NORMAL) begin
        for (int i = 0; i < 3; i++) tri_norm[i] = o[i];
        proj_axis = b.axis & rti_pkg::AXIS_MASK;
        return;
      end
      if (b.kind != rti_pkg::KIND_RAY)
        return;
      rays_seen++;
      res = '{hit: 1'b0, entering: 1'b0, distance: '0};
      dot_d = 0;
      dot_n = 0;
      for (int i = 0; i < 3; i++) begin
        dot_d += scaled_product(tri_norm[i], dv[i]);
        dot_n += scaled_product(tri_norm[i], o[i] - tri_vtx[i]);
      end
      // A zero dot product is parallel even with a zero threshold.
      if (dot_d == 0 || magnitude(dot_d) < threshold) begin
        pending_hits.push_back(res);
        return;
      end
      res.entering = dot_d < 0;
      // Restoring division for t = -num/d, truncated and saturated.
      un = magnitude(dot_n);
      ud = magnitude(dot_d);
      neg = (dot_n != 0) && ((dot_n < 0) == (dot_d < 0));
      q = un / ud;
      r = un % ud;
      if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
      for (int i = 0; i < 16; i++) begin
        q = q << 1;
        r = r << 1;
        if (r >= ud) begin
          r -= ud;
          q++;
        end
        if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
      end
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        t = -longint'(q);
      end else begin
        if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
        t = longint'(q);
      end
      if (t < longint'(b.near_t) || t > longint'(b.far_t)) begin
        pending_hits.push_back(res);
        return;
      end
      case (proj_axis)
        rti_pkg::AXIS_X: begin
          ia = 1;
          ib = 2;
        end
        rti_pkg::AXIS_Y: begin
          ia = 0;
          ib = 2;
        end
        default: begin
          ia = 0;
          ib = 1;
        end
      endcase
      px = o[ia] + scaled_product(dv[ia], t);
      py = o[ib] + scaled_product(dv[ib], t);
      inside_tri = 0;
      for (int i = 0; i < 3; i++) begin
        j = (i < 2) ? i + 1 : 0;
        if (edge_crosses(tri_vtx[i * 3 + ia], tri_vtx[i * 3 + ib],
                         tri_vtx[j * 3 + ia], tri_vtx[j * 3 + ib], px, py))
          inside_tri = !inside_tri;
      end
      if (inside_tri) begin
        res.hit = 1'b1;
        res.distance = t[31:0];
      end
      pending_hits.push_back(res);
    endfunction

    function void check_result(logic got_hit, logic got_entering,
                               logic signed [31:0] got_distance);
      hit_result_t want;
      if (pending_hits.size() == 0) begin
        $error("result beat with no ray outstanding");
        errors++;
        return;
      end
      want = pending_hits.pop_front();
      if (want.hit) hits_seen++;
      if (got_hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, got_hit);
        errors++;
      end
      if (got_entering !== want.entering) begin
        $error("entering: expected %0d, actual %0d", want.entering, got_entering);
        errors++;
      end
      if (got_distance !== want.distance) begin
        $error("distance: expected %0d, actual %0d", want.distance, got_distance);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         kind;
  logic [1:0]         vertex_slot;
  logic signed [31:0] first_x, first_y, first_z;
  logic signed [31:0] second_x, second_y, second_z;
  logic [1:0]         axis_choice;
  logic signed [31:0] near_limit, far_limit;
  logic               out_valid;
  logic               out_stall;
  logic               hit;
  logic               entering;
  logic signed [31:0] distance;
  logic               cfg_write_enable;
  logic [16:0]        cfg_write_data;

  ray_triangle_intersect uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .vertex_slot(vertex_slot),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .axis_choice(axis_choice), .near_limit(near_limit), .far_limit(far_limit),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .entering(entering), .distance(distance),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data)
  );

  hit_scoreboard scoreboard = new();

  // Control shared between the sender and the receiver. quiet turns off all
  // random idling on both sides; hold_request asks the receiver for one long
  // stall so the pipeline backs up into the input.
  bit quiet;
  bit hold_request;
  bit hold_taken;
  int hold_count;
  int idle_cycles;
  beat_t queued_beats[$];

  localparam int UNIT      = 65536;
  localparam int PIPE_WAIT = 60;     // longer than the pipeline latency
  localparam int HOLD_LEN  = 300;
  localparam int STALL_CAP = 5000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: checks each result beat taken at an edge and picks the next
  // stall value. A long hold-off is counted here, in its own process.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        scoreboard.check_result(hit, entering, distance);
      if (hold_request && !hold_taken) begin
        hold_taken = 1;
        hold_count = HOLD_LEN;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 22);
      end
    end
  end

  // Watchdog: the run is hung if no beat moves on either side for too long.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_CAP) begin
        $display("timeout: nothing moved for %0d cycles", STALL_CAP);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic int signed_pick(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic beat_t blank_beat(rti_pkg::kind_t k);
    beat_t b;
    b.kind = k;
    b.slot = '0;
    b.axis = rti_pkg::AXIS_Z;
    for (int i = 0; i < 3; i++) begin
      b.org[i] = '0;
      b.dir[i] = '0;
    end
    b.near_t = 32'sh8000_0000;
    b.far_t = 32'sh7fff_ffff;
    return b;
  endfunction

  // Every field full range, every code including the ignored ones.
  function automatic beat_t noise_beat();
    beat_t b;
    b.kind = rti_pkg::kind_t'($urandom_range(3));
    b.slot = 2'($urandom_range(3));
    b.axis = 2'($urandom_range(3));
    for (int i = 0; i < 3; i++) begin
      b.org[i] = $urandom;
      b.dir[i] = $urandom;
    end
    b.near_t = $urandom;
    b.far_t = $urandom;
    return b;
  endfunction

  function automatic beat_t vertex_beat(int slot, int x, int y, int z);
    beat_t b;
    b = blank_beat(rti_pkg::KIND_VERTEX);
    b.slot = 2'(slot);
    b.org[0] = x;
    b.org[1] = y;
    b.org[2] = z;
    return b;
  endfunction

  function automatic beat_t normal_beat(int x, int y, int z, logic [1:0] axis);
    beat_t b;
    b = blank_beat(rti_pkg::KIND_NORMAL);
    b.org[0] = x;
    b.org[1] = y;
    b.org[2] = z;
    b.axis = axis;
    return b;
  endfunction

  function automatic beat_t ray_beat(int ox, int oy, int oz, int dx, int dy, int dz);
    beat_t b;
    b = blank_beat(rti_pkg::KIND_RAY);
    b.org[0] = ox;
    b.org[1] = oy;
    b.org[2] = oz;
    b.dir[0] = dx;
    b.dir[1] = dy;
    b.dir[2] = dz;
    return b;
  endfunction

  // Current random triangle: it lies in a plane across plane_axis at height
  // plane_level, so rays aimed near it hit often.
  int plane_axis;
  int plane_level;

  task automatic queue_triangle();
    int v[3];
    int ia, ib, nrm[3];
    plane_axis = $urandom_range(2);
    plane_level = signed_pick(64 * UNIT);
    ia = (plane_axis == 0) ? 1 : 0;
    ib = (plane_axis == 2) ? 1 : 2;
    for (int k = 0; k < 3; k++) begin
      v[plane_axis] = plane_level;
      v[ia] = signed_pick(60 * UNIT);
      v[ib] = signed_pick(60 * UNIT);
      queued_beats.push_back(vertex_beat(k, v[0], v[1], v[2]));
    end
    for (int i = 0; i < 3; i++) nrm[i] = 0;
    nrm[plane_axis] = $urandom_range(1) ? UNIT : -UNIT;
    if ($urandom_range(99) < 25)
      for (int i = 0; i < 3; i++) nrm[i] += signed_pick(UNIT / 4);
    queued_beats.push_back(normal_beat(nrm[0], nrm[1], nrm[2],
        (plane_axis == 2 && $urandom_range(1)) ? 2'(rti_pkg::AXIS_ZZ) : 2'(plane_axis)));
  endtask

  function automatic beat_t aimed_ray();
    beat_t b;
    int o[3], goal[3];
    int ia, ib, sh;
    ia = (plane_axis == 0) ? 1 : 0;
    ib = (plane_axis == 2) ? 1 : 2;
    o[ia] = signed_pick(60 * UNIT);
    o[ib] = signed_pick(60 * UNIT);
    o[plane_axis] = plane_level + signed_pick(100 * UNIT);
    goal[ia] = signed_pick(50 * UNIT);
    goal[ib] = signed_pick(50 * UNIT);
    goal[plane_axis] = plane_level;
    sh = $urandom_range(3);
    b = ray_beat(o[0], o[1], o[2], (goal[0] - o[0]) >>> sh, (goal[1] - o[1]) >>> sh,
                 (goal[2] - o[2]) >>> sh);
    if ($urandom_range(99) < 4)
      b.dir[plane_axis] = '0;
    case ($urandom_range(9))
      0: begin
        b.near_t = UNIT / 2;
        b.far_t = UNIT * 2;
      end
      1: begin
        b.near_t = $urandom;
        b.far_t = $urandom;
      end
      2: b.near_t = 0;
      default: ;
    endcase
    return b;
  endfunction

  // Offers one beat, waits for the edge that accepts it, then sometimes idles the input.
  task automatic send_beat(beat_t b);
    in_valid <= 1'b1;
    kind <= b.kind;
    vertex_slot <= b.slot;
    first_x <= b.org[0];
    first_y <= b.org[1];
    first_z <= b.org[2];
    second_x <= b.dir[0];
    second_y <= b.dir[1];
    second_z <= b.dir[2];
    axis_choice <= b.axis;
    near_limit <= b.near_t;
    far_limit <= b.far_t;
    do @(posedge clk); while (in_stall);
    scoreboard.note_input(b);
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_queued();
    while (queued_beats.size() > 0)
      send_beat(queued_beats.pop_front());
  endtask

  // Waits for every ray in flight, then for any load still in the pipe, so
  // the threshold changes only while the block is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending_hits.size() > 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(logic [16:0] value);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    scoreboard.set_threshold(value);
  endtask

  task automatic queue_directed();
    beat_t b;
    // A right triangle in the z = 0 plane, facing +z.
    queued_beats.push_back(vertex_beat(0, 0, 0, 0));
    queued_beats.push_back(vertex_beat(1, 4 * UNIT, 0, 0));
    queued_beats.push_back(vertex_beat(2, 0, 4 * UNIT, 0));
    queued_beats.push_back(normal_beat(0, 0, UNIT, rti_pkg::AXIS_Z));
    // Straight down onto the inside: a hit at t = 5, entering.
    queued_beats.push_back(ray_beat(UNIT, UNIT, 5 * UNIT, 0, 0, -UNIT));
    // From below, leaving through the back face.
    queued_beats.push_back(ray_beat(UNIT, UNIT, -2 * UNIT, 0, 0, UNIT));
    // Pointing away: negative t, cut off by a zero near limit.
    b = ray_beat(UNIT, UNIT, 5 * UNIT, 0, 0, UNIT);
    b.near_t = 0;
    queued_beats.push_back(b);
    // Zero dot product and a dot product just under the threshold.
    queued_beats.push_back(ray_beat(UNIT, UNIT, 5 * UNIT, UNIT, 0, 0));
    queued_beats.push_back(ray_beat(UNIT, UNIT, 5 * UNIT, 0, 0, -65));
    // Outside the triangle.
    queued_beats.push_back(ray_beat(3 * UNIT, 3 * UNIT, 5 * UNIT, 0, 0, -UNIT));
    // Point on the horizontal bottom edge.
    queued_beats.push_back(ray_beat(UNIT, 0, 5 * UNIT, 0, 0, -UNIT));
    // Hit rejected by a far limit below t.
    b = ray_beat(UNIT, UNIT, 5 * UNIT, 0, 0, -UNIT);
    b.far_t = 4 * UNIT;
    queued_beats.push_back(b);
    // Saturating t: tiny direction, far origin.
    queued_beats.push_back(ray_beat(UNIT, UNIT, 32'sh7fff_ffff, 0, 0, -66));
    // Extreme fields everywhere.
    queued_beats.push_back(ray_beat(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                                    32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
    // Ignored beats: vertex slot three and kind three.
    queued_beats.push_back(vertex_beat(3, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    b = noise_beat();
    b.kind = rti_pkg::KIND_NONE;
    queued_beats.push_back(b);
    queued_beats.push_back(ray_beat(UNIT, UNIT, 5 * UNIT, 0, 0, -UNIT));
    // Axis value three projects as z.
    queued_beats.push_back(normal_beat(0, 0, UNIT, rti_pkg::AXIS_ZZ));
    queued_beats.push_back(ray_beat(UNIT, UNIT, 5 * UNIT, UNIT / 8, 0, -UNIT));
    // The same triangle moved into the x = 2 plane, projected across x.
    queued_beats.push_back(vertex_beat(0, 2 * UNIT, 0, 0));
    queued_beats.push_back(vertex_beat(1, 2 * UNIT, 4 * UNIT, 0));
    queued_beats.push_back(vertex_beat(2, 2 * UNIT, 0, 4 * UNIT));
    queued_beats.push_back(normal_beat(-UNIT, 0, 0, rti_pkg::AXIS_X));
    queued_beats.push_back(ray_beat(0, UNIT, UNIT, UNIT, 0, 0));
  endtask

  logic [16:0] phase_threshold[5];

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = rti_pkg::KIND_VERTEX;
    vertex_slot = '0;
    first_x = '0;
    first_y = '0;
    first_z = '0;
    second_x = '0;
    second_y = '0;
    second_z = '0;
    axis_choice = rti_pkg::AXIS_Z;
    near_limit = '0;
    far_limit = '0;
    cfg_write_enable = 1'b0;
    cfg_write_data = '0;
    quiet = 0;
    hold_request = 0;
    hold_taken = 0;
    hold_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    phase_threshold[0] = rti_pkg::THRESHOLD_RESET;
    phase_threshold[1] = 17'd0;
    phase_threshold[2] = 17'd65536;
    phase_threshold[3] = 17'($urandom_range(65536));
    phase_threshold[4] = 17'd1000;

    // Each phase runs with its own threshold; the block is drained before
    // every write. Phase 1 runs with no idling, phase 3 with a long hold-off.
    for (int phase = 0; phase < 5; phase++) begin
      write_threshold(phase_threshold[phase]);
      quiet = (phase == 1);
      if (phase == 0) begin
        queue_directed();
        drain_queued();
      end
      if (phase == 3)
        hold_request = 1;
      queue_triangle();
      drain_queued();
      for (int n = 0; n < 270; n++) begin
        if ($urandom_range(99) < 4) begin
          queue_triangle();
          drain_queued();
        end
        if ($urandom_range(99) < 8)
          send_beat(noise_beat());
        else
          send_beat(aimed_ray());
      end
      wait_idle();
    end

    $display("covered %0d ray beats (%0d hits) over 5 threshold settings,",
             scoreboard.rays_seen, scoreboard.hits_seen);
    $display("with directed corner rays, ignored beats and a long output hold-off");
    if (scoreboard.errors == 0 && scoreboard.pending_hits.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
